>>> hdl/ptd_pkg.sv
package ptd_pkg;

  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_REMOVE     = 3'd1;
  localparam logic [2:0] OP_REMOVE_ALL = 3'd2;
  localparam logic [2:0] OP_HANDLE     = 3'd3;
  localparam logic [2:0] OP_COMPLETE   = 3'd4;
  localparam logic [2:0] OP_ENABLE     = 3'd5;
  localparam logic [2:0] OP_QUERY      = 3'd6;
  localparam logic [2:0] OP_UNUSED     = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        now_ms;
    logic [15:0]        task_id;
    logic [31:0]        period_ms;
    logic signed [31:0] run_count;
    logic [31:0]        start_ms;
    logic [31:0]        stop_ms;
    logic               enable_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        result_id;
    logic               dispatched;
    logic signed [31:0] runs_left;
    logic [31:0]        last_run_ms;
    logic [31:0]        miss_count;
    logic [31:0]        busy_total_ms;
    logic [4:0]         tasks_active;
  } rsp_t;

endpackage

>>> hdl/ptd_ram.sv
module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ptd_ctrl.sv
module ptd_ctrl
  import ptd_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = TIME_BITS;

  typedef struct packed {
    logic [15:0]   id;
    logic [TW-1:0] period;
    logic [31:0]   runs;
    logic [TW-1:0] last;
    logic          en;
    logic          running;
    logic [TW-1:0] last_dur;
    logic [31:0]   misses;
  } rec_t;

  typedef struct packed {
    logic [SW-1:0] nxt;
    logic [SW-1:0] prv;
  } link_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FOUND, S_HANDLE, S_ADD_A, S_ADD_B, S_ADD_C,
    S_UN_P, S_UN_N, S_DONE
  } state_t;

  state_t            state;
  req_t              q;
  logic [SW-1:0]     cur;
  logic [CW-1:0]     total;
  logic [15:0]       id_ctr;
  logic [TW-1:0]     busy;
  logic [MAX_TASKS-1:0] valid;
  logic [SW-1:0]     scan_idx;
  logic              chk_on;
  logic [SW-1:0]     chk_idx;
  logic              free_ok;
  logic [SW-1:0]     free_idx;
  logic [15:0]       key;
  logic [SW-1:0]     slot;
  rec_t              rec_q;
  logic [SW-1:0]     tail;
  logic [SW-1:0]     cur_next;
  logic [SW-1:0]     un_p;
  logic [SW-1:0]     un_n;
  logic [1:0]        status;
  logic [15:0]       rid;
  logic              disp;
  logic [31:0]       qruns;
  logic [31:0]       qlast;
  logic [31:0]       qmiss;

  rec_t              rec_rd;
  link_t             link_rd;
  logic              rec_we;
  logic [SW-1:0]     rec_waddr;
  rec_t              rec_wdata;
  logic [SW-1:0]     rec_raddr;
  logic              link_we;
  logic [SW-1:0]     link_waddr;
  link_t             link_wdata;
  logic [SW-1:0]     link_raddr;

  logic              scan_hit;
  logic              scan_end;
  logic [SW-1:0]     free_slot;
  rec_t              add_rec;
  rec_t              done_rec;
  logic [TW-1:0]     dur;
  logic [TW-1:0]     since;
  logic [TW-1:0]     elapsed;
  logic              task_ready;
  logic              unlink_go;
  logic              was_cur;

  ptd_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_TASKS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rd)
  );

  ptd_ram #(.WIDTH($bits(link_t)), .DEPTH(MAX_TASKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res = '{status: status, result_id: rid, dispatched: disp, runs_left: qruns,
                 last_run_ms: qlast, miss_count: qmiss, busy_total_ms: 32'(busy),
                 tasks_active: 5'(total)};

  // slot scan: one read issued and one entry checked every cycle
  assign scan_hit  = chk_on && valid[chk_idx] && (rec_rd.id == key);
  assign scan_end  = chk_on && !scan_hit && (chk_idx == SW'(MAX_TASKS - 1));
  assign free_slot = free_ok ? free_idx : chk_idx;

  always_comb begin
    add_rec          = rec_t'('0);
    add_rec.id       = key;
    add_rec.period   = TW'(q.period_ms);
    add_rec.runs     = q.run_count;
    add_rec.last     = TW'(q.now_ms);
    add_rec.en       = 1'b1;
  end

  assign dur     = TW'(q.stop_ms) - TW'(q.start_ms);
  assign since   = TW'(q.stop_ms) - rec_q.last;
  assign elapsed = TW'(q.now_ms) - rec_rd.last;
  assign task_ready = rec_rd.en && !rec_rd.running && (elapsed >= rec_rd.period);
  assign was_cur = (slot == cur);

  always_comb begin
    done_rec          = rec_q;
    done_rec.running  = 1'b0;
    if (rec_q.runs != 32'd0 && !rec_q.runs[31]) begin
      done_rec.runs = rec_q.runs - 32'd1;
    end
    done_rec.last_dur = dur;
    if (since > rec_q.period && (since - rec_q.period) > rec_q.period &&
        rec_q.misses != '1) begin
      done_rec.misses = rec_q.misses + 32'd1;
    end
    done_rec.last     = TW'(q.start_ms);
  end

  assign unlink_go = (q.operation == OP_REMOVE) ||
                     (q.operation == OP_COMPLETE && rec_q.running &&
                      done_rec.runs == 32'd0);

  always_comb begin
    rec_raddr  = cur;
    link_raddr = cur;
    rec_we     = 1'b0;
    rec_waddr  = slot;
    rec_wdata  = rec_q;
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = '{nxt: cur, prv: cur};
    unique case (state)
      S_SCAN: begin
        rec_raddr  = scan_idx;
        link_raddr = chk_idx;
        if (scan_end && q.operation == OP_ADD) begin
          link_raddr = cur;
          rec_we     = 1'b1;
          rec_waddr  = free_slot;
          rec_wdata  = add_rec;
          if (total == '0) begin
            link_we    = 1'b1;
            link_waddr = free_slot;
            link_wdata = '{nxt: free_slot, prv: free_slot};
          end
        end
      end
      S_FOUND: begin
        link_raddr = link_rd.prv;
        if (q.operation == OP_ENABLE) begin
          rec_we       = 1'b1;
          rec_wdata.en = q.enable_flag;
        end
        if (q.operation == OP_COMPLETE && rec_q.running) begin
          rec_we    = 1'b1;
          rec_wdata = done_rec;
        end
        if (unlink_go && total > CW'(1) && link_rd.prv == link_rd.nxt) begin
          link_we    = 1'b1;
          link_waddr = link_rd.prv;
          link_wdata = '{nxt: link_rd.prv, prv: link_rd.prv};
        end
      end
      S_UN_P: begin
        link_raddr = un_n;
        link_we    = 1'b1;
        link_waddr = un_p;
        link_wdata = '{nxt: un_n, prv: link_rd.prv};
      end
      S_UN_N: begin
        link_we    = 1'b1;
        link_waddr = un_n;
        link_wdata = '{nxt: link_rd.nxt, prv: un_p};
      end
      S_HANDLE: begin
        if (task_ready) begin
          rec_we            = 1'b1;
          rec_waddr         = cur;
          rec_wdata         = rec_rd;
          rec_wdata.running = 1'b1;
        end
      end
      S_ADD_A: begin
        link_raddr = link_rd.prv;
        link_we    = 1'b1;
        link_waddr = slot;
        link_wdata = '{nxt: cur, prv: link_rd.prv};
      end
      S_ADD_B: begin
        link_we = 1'b1;
        if (tail == cur) begin
          link_waddr = cur;
          link_wdata = '{nxt: slot, prv: slot};
        end else begin
          link_waddr = tail;
          link_wdata = '{nxt: slot, prv: link_rd.prv};
        end
      end
      S_ADD_C: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = '{nxt: cur_next, prv: slot};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cur    <= '0;
      total  <= '0;
      id_ctr <= '0;
      busy   <= '0;
      valid  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            q        <= req;
            status   <= ST_OK;
            rid      <= '0;
            disp     <= 1'b0;
            qruns    <= '0;
            qlast    <= '0;
            qmiss    <= '0;
            scan_idx <= '0;
            chk_on   <= 1'b0;
            free_ok  <= 1'b0;
            key      <= req.task_id;
            if (total == '0 && req.operation != OP_ADD &&
                req.operation != OP_REMOVE_ALL && req.operation <= OP_QUERY) begin
              status <= ST_EMPTY;
              state  <= S_DONE;
            end else begin
              case (req.operation)
                OP_ADD: begin
                  if (total == CW'(MAX_TASKS)) begin
                    status <= ST_FULL;
                    state  <= S_DONE;
                  end else begin
                    key    <= id_ctr;
                    id_ctr <= id_ctr + 16'd1;
                    state  <= S_SCAN;
                  end
                end
                OP_REMOVE_ALL: begin
                  valid <= '0;
                  total <= '0;
                  cur   <= '0;
                  state <= S_DONE;
                end
                OP_HANDLE: state <= S_HANDLE;
                OP_REMOVE, OP_COMPLETE, OP_ENABLE, OP_QUERY: state <= S_SCAN;
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            if (q.operation == OP_ADD) begin
              // id still in use: take the next one and scan again
              key      <= id_ctr;
              id_ctr   <= id_ctr + 16'd1;
              scan_idx <= '0;
              chk_on   <= 1'b0;
              free_ok  <= 1'b0;
            end else begin
              slot  <= chk_idx;
              rec_q <= rec_rd;
              state <= S_FOUND;
            end
          end else if (scan_end) begin
            if (q.operation == OP_ADD) begin
              valid[free_slot] <= 1'b1;
              slot             <= free_slot;
              rid              <= key;
              total            <= total + CW'(1);
              if (total == '0) begin
                cur   <= free_slot;
                state <= S_DONE;
              end else begin
                state <= S_ADD_A;
              end
            end else begin
              status <= ST_NOT_FOUND;
              state  <= S_DONE;
            end
          end else begin
            if (chk_on && !valid[chk_idx] && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= chk_idx;
            end
            chk_on   <= 1'b1;
            chk_idx  <= scan_idx;
            scan_idx <= scan_idx + SW'(1);
          end
        end
        S_FOUND: begin
          state <= S_DONE;
          rid   <= q.task_id;
          if (q.operation == OP_QUERY) begin
            qruns <= rec_q.runs;
            qlast <= 32'(rec_q.last_dur);
            qmiss <= rec_q.misses;
          end else if (q.operation == OP_COMPLETE && !rec_q.running) begin
            status <= ST_NOT_FOUND;
            rid    <= '0;
          end else if (q.operation == OP_REMOVE || q.operation == OP_COMPLETE) begin
            if (q.operation == OP_COMPLETE) begin
              busy <= busy + dur;
            end
            if (unlink_go) begin
              valid[slot] <= 1'b0;
              total       <= total - CW'(1);
              un_p        <= link_rd.prv;
              un_n        <= link_rd.nxt;
              if (total == CW'(1)) begin
                cur <= '0;
              end else begin
                if (was_cur) begin
                  cur <= (q.operation == OP_COMPLETE) ? link_rd.nxt : link_rd.prv;
                end
                if (link_rd.prv != link_rd.nxt) begin
                  state <= S_UN_P;
                end
              end
            end else if (was_cur) begin
              cur <= link_rd.nxt;
            end
          end
        end
        S_UN_P: state <= S_UN_N;
        S_UN_N: state <= S_DONE;
        S_HANDLE: begin
          rid <= rec_rd.id;
          if (task_ready) begin
            disp <= 1'b1;
          end else begin
            cur <= link_rd.nxt;
          end
          state <= S_DONE;
        end
        S_ADD_A: begin
          tail     <= link_rd.prv;
          cur_next <= link_rd.nxt;
          state    <= S_ADD_B;
        end
        S_ADD_B: state <= (tail == cur) ? S_DONE : S_ADD_C;
        S_ADD_C: state <= S_DONE;
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/periodic_task_dispatcher.sv
// Round-robin dispatcher for up to MAX_TASKS periodic tasks.
// Requests arrive as req_t transactions on req_valid/req_ready; every request
// gives exactly one rsp_t transaction on rsp_valid/rsp_ready.
// Task records and ring links sit in two single-port-write memories with a
// registered read; an operation reads, modifies and writes back.
// Work per request, from acceptance to the result in the output register:
//   remove all, empty ring, table full, unused code: no memory access
//   handle one: reads the current slot, dispatches it or moves on
//   remove, complete, set enable, query: the id lookup, then the update
//   (the id lookup reads one slot per cycle and stops at the match; an
//   unknown id walks every slot)
//   add: a scan for a free slot, then the ring links, with a new scan
//   for each id still in use that is skipped.
// One request is handled at a time; the next is taken once the result has
// moved into the output register, even while that result waits.
// A stalled receiver holds the output register; the block finishes the next
// request and then waits with it until the register frees.
// Reset empties the ring and clears the id counter and busy time; the
// memories need no clearing pass.
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic res_valid;
  logic res_ready;
  rsp_t res;

  ptd_ctrl #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= res;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
